/* rtl/core/sdhg_pkg.sv */
// Package for the slot drill hole generator.
// Holds default parameter values and fixed arithmetic constants; no dependencies.
package sdhg_pkg;
    localparam int MAX_HOLES_DEF       = 64;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int COORD_W  = 24;            // coordinate width
    localparam int DIFF_W   = COORD_W + 1;   // coordinate difference width
    localparam int SQ_W     = 50;            // dx^2 + dy^2
    localparam int RHS_W    = 64;            // (dx^2 + dy^2) * 15625
    localparam int RHS_SHIFT = 18;           // remaining power of two of the scale
    localparam int K_W      = 25;            // 125 * d - 4096, signed
    localparam int INDEX_W  = 6;             // hole_index field

    localparam logic [15:0] DRILL_RESET = 16'd3277;
    localparam logic [6:0]  DIA_SCALE   = 7'd125;
    localparam logic [12:0] PROT_TERM   = 13'd4096;
endpackage

/* rtl/core/slot_drill_hole_generator.sv */
// Slot drill hole generator: one slot in, one request per hole out in bisection order.
// Before the first hole: square, scale, count search, divide x then y, fill, seed queue;
// per hole, the queue/hole RAM pop, read, push and output steps (held by stalls).
// One slot at a time; s_axis_tready is high only while idle.
// Reset (synchronous, active low) returns to idle and sets the drill diameter to 3277.
// Depends on sdhg_pkg and sdhg_ram.
module slot_drill_hole_generator
    import sdhg_pkg::*;
#(
    parameter int MAX_HOLES       = MAX_HOLES_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // start_x, start_y, stop_x, stop_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // hole_x, hole_y, hole_index, zero pad
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // count_clamped
);
    localparam int IW   = $clog2(MAX_HOLES);
    localparam int CW   = $clog2(MAX_HOLES + 1);
    localparam int LW   = 2 * IW + 24;
    localparam int CMPW = (LW + 2 * COORD_FRAC_BITS > RHS_W + RHS_SHIFT)
                        ? LW + 2 * COORD_FRAC_BITS : RHS_W + RHS_SHIFT;
    localparam int DIV_STEPS = DIFF_W;
    localparam int SW   = $clog2(DIV_STEPS);

    localparam logic [4:0] S_IDLE = 5'd0,  S_SQX  = 5'd1,  S_SQY  = 5'd2,
                           S_SC0  = 5'd3,  S_SC1  = 5'd4,  S_SC2  = 5'd5,
                           S_SRCH = 5'd6,  S_DIV  = 5'd7,  S_FILL = 5'd8,
                           S_Q0   = 5'd9,  S_Q1   = 5'd10, S_Q2   = 5'd11,
                           S_POP  = 5'd12, S_WQ   = 5'd13, S_PSH1 = 5'd14,
                           S_PSH2 = 5'd15, S_OUT  = 5'd16;

    logic [4:0]  r_state, n_state;
    logic [15:0] r_drill, n_drill;
    logic signed [COORD_W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic signed [DIFF_W-1:0]  r_dx, n_dx, r_dy, n_dy;
    logic [SQ_W-1:0]  r_q, n_q;
    logic [RHS_W-1:0] r_r, n_r;
    logic [LW-1:0] r_l, n_l, r_d, n_d, r_k2, n_k2;
    logic [IW-1:0] r_n, n_n;
    logic [CW-1:0] r_count, n_count, r_emit, n_emit;
    logic          r_clamp, n_clamp;
    logic [IW-1:0] r_den, n_den;
    logic [DIFF_W-1:0] r_dvd, n_dvd;
    logic [IW-1:0] r_rem, n_rem;
    logic [SW-1:0] r_step, n_step;
    logic          r_sel, n_sel;
    logic [DIFF_W-1:0] r_quo_x, n_quo_x, r_quo_y, n_quo_y;
    logic [IW-1:0] r_rmd_x, n_rmd_x, r_rmd_y, n_rmd_y;
    logic [DIFF_W-1:0] r_ax, n_ax, r_ay, n_ay;
    logic [IW-1:0] r_rx, n_rx, r_ry, n_ry;
    logic [IW-1:0] r_m, n_m;
    logic [IW:0]   r_head, n_head, r_tail, n_tail;
    logic [IW-1:0] r_a, n_a, r_b, n_b, r_mid, n_mid;
    logic          r_out_valid, n_out_valid;
    logic [55:0]   r_out_data, n_out_data;
    logic          r_out_last, n_out_last;
    logic          r_out_user, n_out_user;

    // shared multiplier
    logic signed [DIFF_W-1:0]   w_mul_op;
    logic signed [2*DIFF_W-1:0] w_prod;
    logic signed [K_W-1:0]      w_k;
    logic [CMPW-1:0]   w_lhs, w_rhs;
    logic [IW:0]       w_div_t;
    logic [DIFF_W-1:0] w_abs_dx, w_abs_dy;
    logic [IW:0]       w_tx, w_ty;
    logic signed [DIFF_W:0] w_hx, w_hy;
    logic [IW-1:0]     w_qa, w_qb;
    logic [IW:0]       w_mid;

    logic              w_h_we, w_q_we;
    logic [IW-1:0]     w_h_raddr, w_q_waddr, w_q_raddr;
    logic [2*COORD_W-1:0] w_h_wdata, w_h_rdata;
    logic [2*IW-1:0]   w_q_wdata, w_q_rdata;

    sdhg_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_HOLES)) u_hole_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (r_m),
        .i_wdata (w_h_wdata),
        .i_raddr (w_h_raddr),
        .o_rdata (w_h_rdata)
    );

    sdhg_ram #(.WIDTH(2 * IW), .DEPTH(MAX_HOLES)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (w_q_raddr),
        .o_rdata (w_q_rdata)
    );

    assign w_mul_op = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_prod   = w_mul_op * w_mul_op;
    assign w_k      = $signed(K_W'(r_drill) * K_W'(DIA_SCALE)) - $signed(K_W'(PROT_TERM));
    assign w_lhs    = CMPW'(r_l) << (2 * COORD_FRAC_BITS);
    assign w_rhs    = CMPW'(r_r) << RHS_SHIFT;
    assign w_div_t  = {r_rem, r_dvd[DIFF_W-1]};
    assign w_abs_dx = r_dx[DIFF_W-1] ? DIFF_W'(-r_dx) : DIFF_W'(r_dx);
    assign w_abs_dy = r_dy[DIFF_W-1] ? DIFF_W'(-r_dy) : DIFF_W'(r_dy);
    assign w_tx     = {1'b0, r_rx} + {1'b0, r_rmd_x};
    assign w_ty     = {1'b0, r_ry} + {1'b0, r_rmd_y};
    assign w_hx = (DIFF_W + 1)'(r_sx) + (r_dx[DIFF_W-1] ? -$signed({1'b0, r_ax})
                                                        : $signed({1'b0, r_ax}));
    assign w_hy = (DIFF_W + 1)'(r_sy) + (r_dy[DIFF_W-1] ? -$signed({1'b0, r_ay})
                                                        : $signed({1'b0, r_ay}));
    assign w_h_we    = (r_state == S_FILL);
    assign w_h_wdata = {w_hy[COORD_W-1:0], w_hx[COORD_W-1:0]};
    assign w_qa      = w_q_rdata[IW-1:0];
    assign w_qb      = w_q_rdata[2*IW-1:IW];
    assign w_mid     = (({1'b0, w_qa} + (IW + 1)'(1)) >> 1) + ({1'b0, w_qb} >> 1);
    assign w_h_raddr = w_mid[IW-1:0];
    assign w_q_raddr = r_head[IW-1:0];
    assign w_q_waddr = r_tail[IW-1:0];

    // queue pushes
    always_comb begin
        w_q_we    = 1'b0;
        w_q_wdata = {r_b, r_a};
        case (r_state)
            S_Q0: begin
                w_q_we    = 1'b1;
                w_q_wdata = '0;
            end
            S_Q1: begin
                w_q_we    = (r_count > CW'(1));
                w_q_wdata = {2{IW'(r_count - CW'(1))}};
            end
            S_Q2: begin
                w_q_we    = (r_count > CW'(2));
                w_q_wdata = {IW'(r_count - CW'(2)), IW'(1)};
            end
            S_PSH1: begin
                w_q_we    = (r_mid > r_a);
                w_q_wdata = {r_mid - IW'(1), r_a};
            end
            S_PSH2: begin
                w_q_we    = ({1'b0, r_mid} + (IW + 1)'(1) <= {1'b0, r_b});
                w_q_wdata = {r_b, r_mid + IW'(1)};
            end
            default: begin
                w_q_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;   n_drill = r_drill;
        n_sx = r_sx;   n_sy = r_sy;   n_dx = r_dx;   n_dy = r_dy;
        n_q = r_q;     n_r = r_r;     n_l = r_l;     n_d = r_d;   n_k2 = r_k2;
        n_n = r_n;     n_count = r_count;   n_emit = r_emit;   n_clamp = r_clamp;
        n_den = r_den; n_dvd = r_dvd; n_rem = r_rem; n_step = r_step; n_sel = r_sel;
        n_quo_x = r_quo_x; n_quo_y = r_quo_y; n_rmd_x = r_rmd_x; n_rmd_y = r_rmd_y;
        n_ax = r_ax;   n_ay = r_ay;   n_rx = r_rx;   n_ry = r_ry;   n_m = r_m;
        n_head = r_head; n_tail = r_tail; n_a = r_a; n_b = r_b; n_mid = r_mid;
        n_out_valid = r_out_valid; n_out_data = r_out_data;
        n_out_last = r_out_last;   n_out_user = r_out_user;

        if (i_cfg_we) begin
            n_drill = i_cfg_data;
        end
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_q_we) begin
            n_tail = r_tail + (IW + 1)'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sx = s_axis_tdata[23:0];
                    n_sy = s_axis_tdata[47:24];
                    n_dx = DIFF_W'($signed(s_axis_tdata[71:48]))
                         - DIFF_W'($signed(s_axis_tdata[23:0]));
                    n_dy = DIFF_W'($signed(s_axis_tdata[95:72]))
                         - DIFF_W'($signed(s_axis_tdata[47:24]));
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                n_q = SQ_W'(unsigned'(w_prod));
                n_state = S_SQY;
            end
            S_SQY: begin
                n_q = r_q + SQ_W'(unsigned'(w_prod));
                n_state = S_SC0;
            end
            // scale by 15625 = 16384 - 512 - 256 + 8 + 1
            S_SC0: begin
                n_r = (RHS_W'(r_q) << 14) - (RHS_W'(r_q) << 9);
                n_state = S_SC1;
            end
            S_SC1: begin
                n_r = r_r - (RHS_W'(r_q) << 8) + (RHS_W'(r_q) << 3);
                n_state = S_SC2;
            end
            S_SC2: begin
                n_r    = r_r + RHS_W'(r_q);
                n_head = '0;
                n_tail = '0;
                n_emit = '0;
                n_m    = '0;
                n_l    = LW'(unsigned'(w_k));
                n_d    = LW'(unsigned'(w_k)) * LW'(3);
                n_k2   = LW'(unsigned'(w_k)) << 1;
                n_n    = IW'(1);
                if (r_q == '0) begin
                    // single hole at the start point
                    n_count = CW'(1);
                    n_clamp = 1'b0;
                    n_ax    = '0;
                    n_ay    = '0;
                    n_state = S_FILL;
                end else if (w_k <= 0) begin
                    n_count = CW'(MAX_HOLES);
                    n_clamp = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_SRCH;
                end
                n_den  = IW'(MAX_HOLES - 1);
                n_dvd  = w_abs_dx;
                n_rem  = '0;
                n_step = '0;
                n_sel  = 1'b0;
            end
            // walk n^2 * K upward by adding (2n + 1) * K
            S_SRCH: begin
                if (w_lhs >= w_rhs) begin
                    n_count = CW'(r_n) + CW'(1);
                    n_den   = r_n;
                    n_clamp = 1'b0;
                    n_state = S_DIV;
                end else if (r_n == IW'(MAX_HOLES - 1)) begin
                    n_count = CW'(MAX_HOLES);
                    n_clamp = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_l = r_l + r_d;
                    n_d = r_d + r_k2;
                    n_n = r_n + IW'(1);
                end
            end
            // restoring divide of |delta| by count - 1, x then y
            S_DIV: begin
                if (w_div_t >= {1'b0, r_den}) begin
                    n_rem = IW'(w_div_t - {1'b0, r_den});
                    n_dvd = {r_dvd[DIFF_W-2:0], 1'b1};
                end else begin
                    n_rem = w_div_t[IW-1:0];
                    n_dvd = {r_dvd[DIFF_W-2:0], 1'b0};
                end
                n_step = r_step + SW'(1);
                if (r_step == SW'(DIV_STEPS - 1)) begin
                    n_step = '0;
                    if (!r_sel) begin
                        n_quo_x = n_dvd;
                        n_rmd_x = n_rem;
                        n_sel   = 1'b1;
                        n_dvd   = w_abs_dy;
                        n_rem   = '0;
                    end else begin
                        n_quo_y = n_dvd;
                        n_rmd_y = n_rem;
                        n_ax    = '0;
                        n_ay    = '0;
                        n_rx    = r_den >> 1;
                        n_ry    = r_den >> 1;
                        n_state = S_FILL;
                    end
                end
            end
            // hole m sits at start + round(delta * m / (count - 1))
            S_FILL: begin
                if (CW'(r_m) == r_count - CW'(1)) begin
                    n_state = S_Q0;
                end else begin
                    n_m = r_m + IW'(1);
                    if (w_tx >= {1'b0, r_den}) begin
                        n_rx = IW'(w_tx - {1'b0, r_den});
                        n_ax = r_ax + r_quo_x + DIFF_W'(1);
                    end else begin
                        n_rx = w_tx[IW-1:0];
                        n_ax = r_ax + r_quo_x;
                    end
                    if (w_ty >= {1'b0, r_den}) begin
                        n_ry = IW'(w_ty - {1'b0, r_den});
                        n_ay = r_ay + r_quo_y + DIFF_W'(1);
                    end else begin
                        n_ry = w_ty[IW-1:0];
                        n_ay = r_ay + r_quo_y;
                    end
                end
            end
            S_Q0: n_state = S_Q1;
            S_Q1: n_state = S_Q2;
            S_Q2: n_state = S_POP;
            S_POP: begin
                n_head  = r_head + (IW + 1)'(1);
                n_state = S_WQ;
            end
            S_WQ: begin
                n_a     = w_qa;
                n_b     = w_qb;
                n_mid   = w_mid[IW-1:0];
                n_state = S_PSH1;
            end
            S_PSH1: begin
                n_out_valid = 1'b1;
                n_out_data  = {2'b00, INDEX_W'(r_mid), w_h_rdata};
                n_out_last  = (r_emit + CW'(1) == r_count);
                n_out_user  = r_clamp;
                n_emit      = r_emit + CW'(1);
                n_state     = S_PSH2;
            end
            S_PSH2: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = (r_emit == r_count) ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_drill     <= DRILL_RESET;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_emit      <= '0;
            r_step      <= '0;
            r_sel       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_drill     <= n_drill;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_emit      <= n_emit;
            r_step      <= n_step;
            r_sel       <= n_sel;
        end
        r_sx <= n_sx;   r_sy <= n_sy;   r_dx <= n_dx;   r_dy <= n_dy;
        r_q <= n_q;     r_r <= n_r;     r_l <= n_l;     r_d <= n_d;   r_k2 <= n_k2;
        r_n <= n_n;     r_count <= n_count;   r_clamp <= n_clamp;
        r_den <= n_den; r_dvd <= n_dvd; r_rem <= n_rem;
        r_quo_x <= n_quo_x; r_quo_y <= n_quo_y; r_rmd_x <= n_rmd_x; r_rmd_y <= n_rmd_y;
        r_ax <= n_ax;   r_ay <= n_ay;   r_rx <= n_rx;   r_ry <= n_ry;   r_m <= n_m;
        r_a <= n_a;     r_b <= n_b;     r_mid <= n_mid;
        r_out_data <= n_out_data;   r_out_last <= n_out_last;   r_out_user <= n_out_user;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;
endmodule

/* rtl/core/sdhg_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sdhg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
